/* rtl/lsfs_pkg.sv */
// lsfs_pkg: shared types and constants for the LED strip frame serializer.
// No dependencies; imported by the top level, lsfs_seq and lsfs_enc.
`timescale 1ns / 1ps

package lsfs_pkg;

	localparam int LED_COUNT = 64;
	localparam int LED_AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int BITS_PER_LED = 24;
	localparam int COLOR_W = 24;
	localparam int CODE_W = 8;
	localparam int LATCH_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 2;

	localparam logic [4:0] BIT_TOP = 5'(BITS_PER_LED - 1);
	localparam logic [LED_AW-1:0] LED_LAST = LED_AW'(LED_COUNT - 1);

	localparam logic [CODE_W-1:0] ONE_CODE_RESET = 8'hF0;
	localparam logic [CODE_W-1:0] ZERO_CODE_RESET = 8'hC0;
	localparam logic [LATCH_W-1:0] LATCH_RESET = 16'd800;

	typedef enum logic [1:0] {
		MODE_SET = 2'd0,
		MODE_FILL = 2'd1,
		MODE_SHOW = 2'd2,
		MODE_TICK = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_ONE_CODE = 2'd0,
		REG_ZERO_CODE = 2'd1,
		REG_LATCH_TICKS = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SEND = 2'd1,
		PH_LATCH = 2'd2
	} phase_t;

	// word handed from the sequencer to the output encoder
	typedef struct packed {
		logic       vld;
		logic       send;
		logic [4:0] bit_idx;
		logic       use_mem;
		logic       done;
		logic       reject;
	} tick_info_t;

endpackage

/* rtl/led_strip_frame_serializer.sv */
// led_strip_frame_serializer: top level; configuration registers and wiring.
// Depends on lsfs_pkg, lsfs_ram, lsfs_seq, lsfs_enc.
`timescale 1ns / 1ps

// Serializes a 64-entry store of 24-bit GRB colors into one code byte per
// color bit. Every input word yields exactly one result word, registered first
// alongside the color RAM read and then in the output register.
// Words are accepted one per cycle sustained, ticks included, as long as the
// output side keeps taking results; the RAM read port and the output register
// form the two-deep pipeline that sets this. A fill clears the per-LED valid
// bits and stores the fill color; entries not written since then read as the
// fill color, so there is no sweep of the RAM and no clearing pass after reset.
// Write configuration only while the block is idle.

module led_strip_frame_serializer import lsfs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             mode,
	input  logic [5:0]             led_index,
	input  logic [7:0]             red,
	input  logic [7:0]             green,
	input  logic [7:0]             blue,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             code_byte,
	output logic                   byte_valid,
	output logic                   frame_done,
	output logic                   busy_reject,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [CODE_W-1:0]  one_code_q;
	logic [CODE_W-1:0]  zero_code_q;
	logic [LATCH_W-1:0] latch_ticks_q;
	tick_info_t         info_s1;
	logic               take;
	logic [COLOR_W-1:0] fill_color;
	logic               ram_we;
	logic [LED_AW-1:0]  ram_waddr;
	logic [COLOR_W-1:0] ram_wdata;
	logic               ram_re;
	logic [LED_AW-1:0]  ram_raddr;
	logic [COLOR_W-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_code_q <= ONE_CODE_RESET;
			zero_code_q <= ZERO_CODE_RESET;
			latch_ticks_q <= LATCH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ONE_CODE: one_code_q <= cfg_data[CODE_W-1:0];
				REG_ZERO_CODE: zero_code_q <= cfg_data[CODE_W-1:0];
				REG_LATCH_TICKS: latch_ticks_q <= cfg_data[LATCH_W-1:0];
				default: ;
			endcase
		end
	end

	lsfs_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.led_index  (led_index),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.latch_ticks(latch_ticks_q),
		.take       (take),
		.info_s1    (info_s1),
		.fill_color (fill_color),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr)
	);

	lsfs_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(LED_COUNT)
	) u_color_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	lsfs_enc u_enc (
		.clk        (clk),
		.arst_n     (arst_n),
		.info_s1    (info_s1),
		.rd_data    (ram_rdata),
		.fill_color (fill_color),
		.one_code   (one_code_q),
		.zero_code  (zero_code_q),
		.take       (take),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_byte  (code_byte),
		.byte_valid (byte_valid),
		.frame_done (frame_done),
		.busy_reject(busy_reject)
	);

endmodule

/* rtl/lsfs_ram.sv */
// lsfs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lsfs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic             clk,
	input  logic             we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/lsfs_seq.sv */
// lsfs_seq: frame sequencer. Takes input words, keeps phase, pointers and
// per-LED valid bits, drives the color RAM. Uses lsfs_pkg.
`timescale 1ns / 1ps

module lsfs_seq import lsfs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             mode,
	input  logic [5:0]             led_index,
	input  logic [7:0]             red,
	input  logic [7:0]             green,
	input  logic [7:0]             blue,
	input  logic [LATCH_W-1:0]     latch_ticks,
	input  logic                   take,
	output tick_info_t             info_s1,
	output logic [COLOR_W-1:0]     fill_color,
	output logic                   ram_we,
	output logic [LED_AW-1:0]      ram_waddr,
	output logic [COLOR_W-1:0]     ram_wdata,
	output logic                   ram_re,
	output logic [LED_AW-1:0]      ram_raddr
);

	phase_t               phase_q, phase_d;
	logic [LED_AW-1:0]    lp_q;
	logic [4:0]           bp_q;
	logic [LATCH_W-1:0]   cnt_q;
	logic [LATCH_W-1:0]   cnt_dec;
	logic [LED_COUNT-1:0] ent_valid_q;
	logic [COLOR_W-1:0]   fill_color_q;
	logic [COLOR_W-1:0]   color;
	logic                 acc;
	logic                 is_tick;
	logic                 idx_ok;
	logic                 last_bit;
	logic                 last_led;
	tick_info_t           info_d;

	assign in_stall = info_s1.vld & ~take;
	assign acc = in_valid & ~in_stall;
	assign is_tick = mode_t'(mode) == MODE_TICK;
	assign color = {green, red, blue};
	assign idx_ok = 32'(led_index) < 32'(LED_COUNT);
	assign last_bit = bp_q == BIT_TOP;
	assign last_led = last_bit && (lp_q == LED_LAST);
	assign cnt_dec = cnt_q - LATCH_W'(1);
	assign fill_color = fill_color_q;

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (acc) begin
			if (!is_tick) begin
				if (phase_q == PH_IDLE &&
					(mode_t'(mode) == MODE_FILL || mode_t'(mode) == MODE_SHOW)) begin
					phase_d = PH_SEND;
				end
			end else begin
				unique case (phase_q)
					PH_SEND: begin
						if (last_led) begin
							phase_d = (latch_ticks == '0) ? PH_IDLE : PH_LATCH;
						end
					end
					PH_LATCH: begin
						if (cnt_dec == '0) begin
							phase_d = PH_IDLE;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// memory access and the word for the output stage
	always_comb begin
		info_d = '0;
		info_d.vld = 1'b1;
		ram_we = 1'b0;
		ram_waddr = LED_AW'(led_index);
		ram_wdata = color;
		ram_re = 1'b0;
		ram_raddr = lp_q;
		if (!is_tick) begin
			if (phase_q != PH_IDLE) begin
				info_d.reject = 1'b1;
			end else if (mode_t'(mode) == MODE_SET) begin
				ram_we = acc & idx_ok;
			end
		end else begin
			unique case (phase_q)
				PH_SEND: begin
					ram_re = acc;
					info_d.send = 1'b1;
					info_d.bit_idx = bp_q;
					info_d.use_mem = ent_valid_q[lp_q];
					info_d.done = last_led && (latch_ticks == '0);
				end
				PH_LATCH: info_d.done = cnt_dec == '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			lp_q <= '0;
			bp_q <= '0;
			cnt_q <= '0;
			ent_valid_q <= '0;
			fill_color_q <= '0;
			info_s1 <= '0;
		end else begin
			phase_q <= phase_d;
			if (acc) begin
				info_s1 <= info_d;
			end else if (take) begin
				info_s1.vld <= 1'b0;
			end
			if (acc && !is_tick && phase_q == PH_IDLE) begin
				unique case (mode_t'(mode))
					MODE_SET: begin
						if (idx_ok) begin
							ent_valid_q[LED_AW'(led_index)] <= 1'b1;
						end
					end
					MODE_FILL: begin
						// entries not marked valid read as the fill color
						ent_valid_q <= '0;
						fill_color_q <= color;
						lp_q <= '0;
						bp_q <= '0;
						cnt_q <= '0;
					end
					default: begin
						lp_q <= '0;
						bp_q <= '0;
						cnt_q <= '0;
					end
				endcase
			end
			if (acc && is_tick) begin
				if (phase_q == PH_SEND) begin
					if (last_bit) begin
						bp_q <= '0;
						lp_q <= last_led ? '0 : lp_q + LED_AW'(1);
					end else begin
						bp_q <= bp_q + 5'd1;
					end
					if (last_led) begin
						cnt_q <= latch_ticks;
					end
				end else if (phase_q == PH_LATCH) begin
					cnt_q <= cnt_dec;
				end
			end
		end
	end

endmodule

/* rtl/lsfs_enc.sv */
// lsfs_enc: output stage. Picks the color bit from RAM data or the fill
// color, maps it to a code byte and holds the result word. Uses lsfs_pkg.
`timescale 1ns / 1ps

module lsfs_enc import lsfs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  tick_info_t         info_s1,
	input  logic [COLOR_W-1:0] rd_data,
	input  logic [COLOR_W-1:0] fill_color,
	input  logic [CODE_W-1:0]  one_code,
	input  logic [CODE_W-1:0]  zero_code,
	output logic               take,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CODE_W-1:0]  code_byte,
	output logic               byte_valid,
	output logic               frame_done,
	output logic               busy_reject
);

	logic [COLOR_W-1:0] color;
	logic               lit;
	logic [CODE_W-1:0]  code_d;
	logic               out_valid_q;

	assign take = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;
	assign color = info_s1.use_mem ? rd_data : fill_color;
	assign lit = color[BIT_TOP - info_s1.bit_idx];

	always_comb begin
		code_d = '0;
		if (info_s1.send) begin
			code_d = lit ? one_code : zero_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= info_s1.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (take && info_s1.vld) begin
			code_byte <= code_d;
			byte_valid <= info_s1.send;
			frame_done <= info_s1.done;
			busy_reject <= info_s1.reject;
		end
	end

endmodule

/* tb/sv/led_strip_frame_serializer_tb.sv */
// led_strip_frame_serializer_tb: self-checking bench for the LED strip serializer.
// Depends on lsfs_pkg and led_strip_frame_serializer; a local model tracks the
// color store and frame sequencing to check every result word.
`timescale 1ns / 1ps

module led_strip_frame_serializer_tb;
	import lsfs_pkg::*;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int PRINT_CAP = 100;
	// register slot with no register behind it; writes must be dropped
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

	typedef struct packed {
		mode_t      mode;
		logic [5:0] idx;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} strip_word_t;

	typedef struct packed {
		logic [7:0] code;
		logic       valid;
		logic       done;
		logic       reject;
	} strip_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = 2'd0;
	logic [5:0] led_index = 6'd0;
	logic [7:0] red = 8'd0;
	logic [7:0] green = 8'd0;
	logic [7:0] blue = 8'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] code_byte;
	logic byte_valid;
	logic frame_done;
	logic busy_reject;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	led_strip_frame_serializer DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .led_index(led_index), .red(red), .green(green), .blue(blue),
		.out_valid(out_valid), .out_stall(out_stall),
		.code_byte(code_byte), .byte_valid(byte_valid),
		.frame_done(frame_done), .busy_reject(busy_reject),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// local copy of the block's state
	logic [23:0] grb_store [LED_COUNT];
	int send_led;
	int send_bit;
	phase_t strip_phase;
	logic [15:0] latch_left;
	logic [7:0] one_pat;
	logic [7:0] zero_pat;
	logic [15:0] latch_len;

	strip_word_t words_to_send[$];
	strip_result_t code_results_due[$];
	strip_result_t next_res;

	int mismatch_count = 0;
	int cycle_count = 0;
	int burst_left;
	int gap_left;
	int stall_window;
	stall_style_t stall_style;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic serialize_word(input strip_word_t w, output strip_result_t r);
		r = '0;
		if (w.mode != MODE_TICK) begin
			if (strip_phase != PH_IDLE) begin
				r.reject = 1'b1;
			end else if (w.mode == MODE_SET) begin
				if (int'(w.idx) < LED_COUNT) grb_store[w.idx] = {w.g, w.r, w.b};
			end else begin
				if (w.mode == MODE_FILL) begin
					for (int i = 0; i < LED_COUNT; i++) grb_store[i] = {w.g, w.r, w.b};
				end
				send_led = 0;
				send_bit = 0;
				latch_left = '0;
				strip_phase = PH_SEND;
			end
		end else if (strip_phase == PH_SEND) begin
			r.code = grb_store[send_led][23 - send_bit] ? one_pat : zero_pat;
			r.valid = 1'b1;
			send_bit++;
			if (send_bit >= BITS_PER_LED) begin
				send_bit = 0;
				send_led++;
			end
			if (send_led >= LED_COUNT) begin
				send_led = 0;
				send_bit = 0;
				if (latch_len == 0) begin
					r.done = 1'b1;
					strip_phase = PH_IDLE;
				end else begin
					latch_left = latch_len;
					strip_phase = PH_LATCH;
				end
			end
		end else if (strip_phase == PH_LATCH) begin
			if (latch_left > 0) latch_left--;
			if (latch_left == 0) begin
				r.done = 1'b1;
				strip_phase = PH_IDLE;
			end
		end
	endtask

	// ticks still needed before the frame in progress completes
	function automatic int ticks_to_idle();
		if (strip_phase == PH_SEND)
			return (LED_COUNT - send_led) * BITS_PER_LED - send_bit + int'(latch_len);
		if (strip_phase == PH_LATCH) return int'(latch_left);
		return 0;
	endfunction

	task automatic flag_mismatch(input string field, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch %s: got %0d want %0d at cycle %0d", field, got, want,
				cycle_count);
	endtask

	// sender: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= MODE_SET;
			led_index <= '0;
			red <= '0;
			green <= '0;
			blue <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				serialize_word(words_to_send[0], next_res);
				code_results_due.push_back(next_res);
				void'(words_to_send.pop_front());
				if (burst_left > 0) burst_left--;
			end
			if (!(in_valid && in_stall)) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(200, 600)
						: $urandom_range(1, 40);
					gap_left = $urandom_range(0, 8);
				end
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (words_to_send.size() > 0) begin
					in_valid <= 1'b1;
					mode <= words_to_send[0].mode;
					led_index <= words_to_send[0].idx;
					red <= words_to_send[0].r;
					green <= words_to_send[0].g;
					blue <= words_to_send[0].b;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each taken word and stalls on a changing pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_window = 0;
			stall_style = STALL_NONE;
		end else begin
			if (out_valid && !out_stall) begin
				if (code_results_due.size() == 0) begin
					flag_mismatch("unexpected word", 1, 0);
				end else begin
					next_res = code_results_due.pop_front();
					if (code_byte !== next_res.code)
						flag_mismatch("code_byte", code_byte, next_res.code);
					if (byte_valid !== next_res.valid)
						flag_mismatch("byte_valid", byte_valid, next_res.valid);
					if (frame_done !== next_res.done)
						flag_mismatch("frame_done", frame_done, next_res.done);
					if (busy_reject !== next_res.reject)
						flag_mismatch("busy_reject", busy_reject, next_res.reject);
				end
			end
			if (stall_window == 0) begin
				stall_style = stall_style_t'($urandom_range(0, 3));
				stall_window = $urandom_range(20, 300);
			end else begin
				stall_window--;
			end
			case (stall_style)
				STALL_NONE: out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (stall_window % 4 == 0);
			endcase
		end
	end

	task automatic add_word(input mode_t m, input logic [5:0] idx, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		strip_word_t w;
		w.mode = m;
		w.idx = idx;
		w.r = r;
		w.g = g;
		w.b = b;
		words_to_send.push_back(w);
	endtask

	// don't-care fields of a tick still carry random bits
	task automatic add_tick();
		add_word(MODE_TICK, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic wait_idle();
		while (words_to_send.size() != 0 || code_results_due.size() != 0) @(posedge clk);
	endtask

	task automatic finish_frame();
		int n;
		wait_idle();
		n = ticks_to_idle();
		while (n > 0) begin
			repeat (n) add_tick();
			wait_idle();
			n = ticks_to_idle();
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_ONE_CODE: one_pat = data[7:0];
			REG_ZERO_CODE: zero_pat = data[7:0];
			REG_LATCH_TICKS: latch_len = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		for (int i = 0; i < LED_COUNT; i++) grb_store[i] = '0;
		send_led = 0;
		send_bit = 0;
		strip_phase = PH_IDLE;
		latch_left = '0;
		one_pat = ONE_CODE_RESET;
		zero_pat = ZERO_CODE_RESET;
		latch_len = LATCH_RESET;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// short latch so a whole frame fits the run; reset codes stay in place
		write_reg(REG_LATCH_TICKS, 16'($urandom_range(0, 6)));

		// idle ticks, edge LEDs and some random ones, then one full frame
		// with busy commands mixed into the ticks
		add_tick();
		add_tick();
		add_word(MODE_SET, 6'd0, 8'h00, 8'hFF, 8'h81);
		add_word(MODE_SET, 6'd63, 8'hFF, 8'h00, 8'h7E);
		add_word(MODE_SET, 6'd1, 8'h5A, 8'hA5, 8'h00);
		add_word(MODE_SET, 6'd62, 8'hFF, 8'hFF, 8'hFF);
		repeat (20) add_word(MODE_SET, 6'($urandom), pick_level(), pick_level(),
			pick_level());
		add_word(MODE_SHOW, 6'd0, 8'h00, 8'h00, 8'h00);
		repeat (LED_COUNT * BITS_PER_LED) begin
			if ($urandom_range(0, 49) == 0)
				add_word(mode_t'($urandom_range(0, 2)), 6'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom));
			add_tick();
		end
		finish_frame();
		add_tick();
		wait_idle();

		// written codes, a dropped write to the spare slot, then a fill that
		// is ticked through its first two LEDs
		write_reg(REG_ONE_CODE, 16'($urandom));
		write_reg(REG_ZERO_CODE, 16'($urandom));
		write_reg(REG_SPARE, 16'hFFFF);
		write_reg(REG_LATCH_TICKS, 16'($urandom_range(1, 40)));
		add_word(MODE_SET, 6'd33, 8'hC3, 8'h3C, 8'h99);
		add_word(MODE_FILL, 6'($urandom), pick_level(), pick_level(), pick_level());
		add_word(MODE_SHOW, 6'd0, 8'h00, 8'h00, 8'h00);
		repeat (2 * BITS_PER_LED) add_tick();

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* led_strip_frame_serializer.f */
rtl/lsfs_pkg.sv
rtl/lsfs_ram.sv
rtl/lsfs_seq.sv
rtl/lsfs_enc.sv
rtl/led_strip_frame_serializer.sv
tb/sv/led_strip_frame_serializer_tb.sv
